### rtl/core/rpl_pkg.sv
// rpl_pkg: shared types and constants of the regex pattern lexer.
// Holds the byte and token transfer structs, the lexer mode enum and token codes.
// No dependencies.
package rpl_pkg;

	// saturating width of the brace count
	localparam int COUNT_BITS = 16;

	// token kinds
	localparam logic [2:0] TK_CHAR = 3'd0;
	localparam logic [2:0] TK_ESC  = 3'd1;
	localparam logic [2:0] TK_OP   = 3'd2;
	localparam logic [2:0] TK_SKIP = 3'd3;
	localparam logic [2:0] TK_INT  = 3'd4;
	localparam logic [2:0] TK_EOE  = 3'd5;

	// error codes
	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_ESC  = 2'd1;
	localparam logic [1:0] ERR_HEX  = 2'd2;
	localparam logic [1:0] ERR_SKIP = 2'd3;

	// special bytes
	localparam logic [7:0] CH_CARET  = 8'h5e;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_EQUALS = 8'h3d;

	// results per byte
	localparam int MAX_RES = 3;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'd0,
		MODE_ESC    = 3'd1,
		MODE_HEX1   = 3'd2,
		MODE_HEX2   = 3'd3,
		MODE_PAREN  = 3'd4,
		MODE_QMARK  = 3'd5,
		MODE_DRAIN  = 3'd6
	} mode_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       last_char;
	} char_t;

	typedef struct packed {
		logic [2:0]  token_kind;
		logic [15:0] token_value;
		logic [1:0]  error_code;
		logic        last_token;
	} token_t;

	// results of one byte, packed to the low slots
	typedef struct packed {
		logic [1:0]           cnt;
		token_t [MAX_RES-1:0] tok;
	} bundle_t;

endpackage

### rtl/core/rpl_lexer.sv
// rpl_lexer: lexer state registers and combinational byte decode.
// Produces up to three tokens per accepted byte as one bundle.
// Depends on rpl_pkg.
module rpl_lexer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  rpl_pkg::char_t  char_data,
	output rpl_pkg::bundle_t res
);

	localparam int CW = rpl_pkg::COUNT_BITS;

	rpl_pkg::mode_t mode_q, mode_n;
	logic [7:0]     prev_q, prev_n;
	logic           start_q, start_n;
	logic           class_q, class_n;
	logic           brace_q, brace_n;
	logic           pend_q, pend_n;
	logic [CW-1:0]  num_q, num_n;
	logic [3:0]     hexh_q, hexh_n;

	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		// bit 4 flags a valid digit
		logic [4:0] r;
		r = 5'd0;
		if (c >= "0" && c <= "9")
			r = {1'b1, 4'(c - 8'h30)};
		else if (c >= "a" && c <= "f")
			r = {1'b1, 4'(c - 8'h57)};
		else if (c >= "A" && c <= "F")
			r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	always_comb begin
		logic [7:0]     c;
		logic           last;
		logic           do_norm;
		logic           main_v;
		rpl_pkg::token_t main_t;
		logic [1:0]     err;
		logic           eoe_v;
		rpl_pkg::token_t eoe_t;
		logic           flush;
		rpl_pkg::token_t int_t;
		logic [4:0]     hd;
		logic [CW+3:0]  wide;
		logic [CW+15:0] numx;
		logic [1:0]     k;

		c       = char_data.char_in;
		last    = char_data.last_char;
		mode_n  = mode_q;
		prev_n  = prev_q;
		start_n = start_q;
		class_n = class_q;
		brace_n = brace_q;
		pend_n  = pend_q;
		num_n   = num_q;
		hexh_n  = hexh_q;
		do_norm = 1'b0;
		main_v  = 1'b0;
		main_t  = '{token_kind: rpl_pkg::TK_CHAR, token_value: {8'd0, c},
			error_code: rpl_pkg::ERR_NONE, last_token: 1'b0};
		err     = rpl_pkg::ERR_NONE;
		eoe_v   = 1'b0;
		eoe_t   = '{token_kind: rpl_pkg::TK_EOE, token_value: 16'd0,
			error_code: rpl_pkg::ERR_NONE, last_token: 1'b1};
		hd      = hex_digit(c);
		wide    = ({4'd0, num_q} << 3) + ({4'd0, num_q} << 1) + (CW+4)'(c - 8'h30);
		numx    = {16'd0, num_q};
		int_t   = '{token_kind: rpl_pkg::TK_INT, token_value: numx[15:0],
			error_code: rpl_pkg::ERR_NONE, last_token: 1'b0};
		flush   = 1'b0;

		if (mode_q == rpl_pkg::MODE_DRAIN) begin
			// skipping to end of pattern after an error
		end else begin
			flush = pend_q && (c == "," || c == "}");
			if (flush) begin
				pend_n = 1'b0;
				num_n  = '0;
			end
			unique case (mode_q)
				rpl_pkg::MODE_ESC: begin
					mode_n = rpl_pkg::MODE_NORMAL;
					unique case (c)
						"(", ")", "[", "]", "+", "*", "?", ".", rpl_pkg::CH_BSLASH,
						"|", rpl_pkg::CH_CARET, rpl_pkg::CH_DOLLAR, "{", "}", "-":
							main_v = 1'b1;
						"n": begin main_v = 1'b1; main_t.token_value = 16'd10; end
						"t": begin main_v = 1'b1; main_t.token_value = 16'd9;  end
						"r": begin main_v = 1'b1; main_t.token_value = 16'd13; end
						"v": begin main_v = 1'b1; main_t.token_value = 16'd11; end
						"f": begin main_v = 1'b1; main_t.token_value = 16'd12; end
						"e", "w", "W", "d", "D", "s", "S", "a", "A", "l", "L", "u", "U":
						begin
							main_v = 1'b1;
							main_t.token_kind = rpl_pkg::TK_ESC;
						end
						rpl_pkg::CH_X: mode_n = rpl_pkg::MODE_HEX1;
						default: err = rpl_pkg::ERR_ESC;
					endcase
				end
				rpl_pkg::MODE_HEX1: begin
					if (!hd[4]) begin
						err = rpl_pkg::ERR_HEX;
					end else begin
						hexh_n = hd[3:0];
						mode_n = rpl_pkg::MODE_HEX2;
					end
				end
				rpl_pkg::MODE_HEX2: begin
					if (!hd[4]) begin
						err = rpl_pkg::ERR_HEX;
					end else begin
						main_v = 1'b1;
						main_t.token_value = {8'd0, hexh_q, hd[3:0]};
						mode_n = rpl_pkg::MODE_NORMAL;
					end
				end
				rpl_pkg::MODE_QMARK: begin
					if (c == rpl_pkg::CH_BANG || c == rpl_pkg::CH_EQUALS) begin
						main_v = 1'b1;
						main_t.token_kind = rpl_pkg::TK_SKIP;
						mode_n = rpl_pkg::MODE_NORMAL;
					end else begin
						err = rpl_pkg::ERR_SKIP;
					end
				end
				rpl_pkg::MODE_PAREN: begin
					if (c == "?") begin
						mode_n = rpl_pkg::MODE_QMARK;
					end else begin
						mode_n  = rpl_pkg::MODE_NORMAL;
						do_norm = 1'b1;
					end
				end
				default: begin
					// normal mode, and the unused code 7 behaves the same
					mode_n  = rpl_pkg::MODE_NORMAL;
					do_norm = 1'b1;
				end
			endcase

			if (do_norm) begin
				unique case (c)
					rpl_pkg::CH_CARET: begin
						main_v = 1'b1;
						if (start_q || prev_q == "[") main_t.token_kind = rpl_pkg::TK_OP;
					end
					rpl_pkg::CH_DOLLAR: begin
						main_v = 1'b1;
						if (last) main_t.token_kind = rpl_pkg::TK_OP;
					end
					".": begin
						main_v = 1'b1;
						if (!class_q) main_t.token_kind = rpl_pkg::TK_ESC;
					end
					rpl_pkg::CH_BSLASH: mode_n = rpl_pkg::MODE_ESC;
					"[", "]": begin
						class_n = (c == "[");
						main_v  = 1'b1;
						main_t.token_kind = rpl_pkg::TK_OP;
					end
					"-": begin
						main_v = 1'b1;
						if (class_q) main_t.token_kind = rpl_pkg::TK_OP;
					end
					",": begin
						main_v = 1'b1;
						if (brace_q) main_t.token_kind = rpl_pkg::TK_OP;
					end
					"|", "(", ")", "{", "}", "+", "*", "?": begin
						if (c == "(") mode_n = rpl_pkg::MODE_PAREN;
						brace_n = (c == "{");
						main_v  = 1'b1;
						if (!class_q) main_t.token_kind = rpl_pkg::TK_OP;
					end
					"0", "1", "2", "3", "4", "5", "6", "7", "8", "9": begin
						if (!brace_q) begin
							main_v = 1'b1;
						end else begin
							pend_n = 1'b1;
							// saturate when ten times the count plus digit overflows
							if (wide[CW+3:CW] != 4'd0) num_n = '1;
							else num_n = wide[CW-1:0];
						end
					end
					default: main_v = 1'b1;
				endcase
			end

			if (err != rpl_pkg::ERR_NONE) begin
				main_v = 1'b0;
				eoe_v  = 1'b1;
				eoe_t.token_value = {8'd0, c};
				eoe_t.error_code  = err;
				mode_n = rpl_pkg::MODE_DRAIN;
			end else begin
				prev_n  = c;
				start_n = 1'b0;
				if (last) begin
					eoe_v = 1'b1;
					if (mode_n != rpl_pkg::MODE_NORMAL) begin
						eoe_t.token_value = {8'd0, c};
						eoe_t.error_code  = (mode_n == rpl_pkg::MODE_ESC) ?
							rpl_pkg::ERR_ESC : rpl_pkg::ERR_HEX;
					end
				end
			end
		end

		// last byte always returns the lexer to its reset state
		if (last) begin
			mode_n  = rpl_pkg::MODE_NORMAL;
			prev_n  = 8'd0;
			start_n = 1'b1;
			class_n = 1'b0;
			brace_n = 1'b0;
			pend_n  = 1'b0;
			num_n   = '0;
			hexh_n  = 4'd0;
		end

		// pack results in order: count flush, main token, end/error
		res.tok = {rpl_pkg::MAX_RES{eoe_t}};
		k = 2'd0;
		if (flush) begin
			res.tok[k] = int_t;
			k = k + 2'd1;
		end
		if (main_v) begin
			res.tok[k] = main_t;
			k = k + 2'd1;
		end
		if (eoe_v) begin
			res.tok[k] = eoe_t;
			k = k + 2'd1;
		end
		res.cnt = k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= rpl_pkg::MODE_NORMAL;
			prev_q  <= 8'd0;
			start_q <= 1'b1;
			class_q <= 1'b0;
			brace_q <= 1'b0;
			pend_q  <= 1'b0;
			num_q   <= '0;
			hexh_q  <= 4'd0;
		end else if (accept) begin
			mode_q  <= mode_n;
			prev_q  <= prev_n;
			start_q <= start_n;
			class_q <= class_n;
			brace_q <= brace_n;
			pend_q  <= pend_n;
			num_q   <= num_n;
			hexh_q  <= hexh_n;
		end
	end

endmodule

### rtl/core/regex_pattern_lexer_top.sv
// Regex pattern lexer, top level: byte transfers in, token transfers out.
// Tokens of an accepted byte go to the bundle buffer, then to the output register.
// Throughput: one byte per cycle while each byte gives at most one token and the token
// side is not stalled; more tokens from a byte drain one a cycle and stall the input.
// Reset: arst_n asynchronously empties the token buffers and returns the lexer
// to its start-of-pattern state.
module regex_pattern_lexer_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            char_valid,
	output logic            char_stall,
	input  rpl_pkg::char_t  char_data,
	output logic            token_valid,
	input  logic            token_stall,
	output rpl_pkg::token_t token_data
);

	logic             accept;
	logic             out_free;
	logic             pop;
	rpl_pkg::bundle_t res;

	// tokens of the last accepted byte still waiting for the output register
	logic [1:0]                    cnt_q;
	rpl_pkg::token_t [rpl_pkg::MAX_RES-1:0] slot_q;

	logic            out_valid_q;
	rpl_pkg::token_t out_q;

	// output register can load when empty or when its token leaves this cycle
	assign out_free = !out_valid_q || !token_stall;
	assign pop      = out_free && (cnt_q != 2'd0);

	// a new byte is taken once the pending bundle drains, at the latest this cycle
	assign char_stall = (cnt_q > 2'd1) || ((cnt_q == 2'd1) && !out_free);
	assign accept     = char_valid && !char_stall;

	rpl_lexer u_lexer (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_data (char_data),
		.res       (res)
	);

	// bundle buffer: reload on accept, otherwise shift down by one per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (accept) begin
			cnt_q <= res.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q <= res.tok;
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

	// output register parts the token port from the lexer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (cnt_q != 2'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= slot_q[0];
		end
	end

	assign token_valid = out_valid_q;
	assign token_data  = out_q;

endmodule

### rtl/core/rpl_checker.sv
// rpl_checker: port-level assertions for the regex pattern lexer top.
// Bound to regex_pattern_lexer_top below; depends on rpl_pkg.
module rpl_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            char_valid,
	input logic            char_stall,
	input rpl_pkg::char_t  char_data,
	input logic            token_valid,
	input logic            token_stall,
	input rpl_pkg::token_t token_data
);

	// a stalled token stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_stall |=> token_valid && $stable(token_data))
		else $error("stalled token changed");

	// errors only on the closing end-of-expression token
	a_err_eoe: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && (token_data.error_code != rpl_pkg::ERR_NONE) |->
		(token_data.token_kind == rpl_pkg::TK_EOE) && token_data.last_token)
		else $error("error code on non-final token");

	// the final token of a pattern is always end of expression
	a_last_eoe: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_data.last_token |->
		token_data.token_kind == rpl_pkg::TK_EOE)
		else $error("last token is not end of expression");

	// end of expression never appears without closing the pattern
	a_eoe_last: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && (token_data.token_kind == rpl_pkg::TK_EOE) |->
		token_data.last_token)
		else $error("end of expression without last mark");

endmodule

bind regex_pattern_lexer_top rpl_checker u_rpl_checker (.*);

### dv/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for regex_pattern_lexer_top, byte transfers in, tokens out.
// A scoreboard class predicts the tokens of each accepted byte; tasks drive the patterns.
// Depends on rpl_pkg and the RTL of regex_pattern_lexer_top.
module testbench;

	// Token prediction and checking. Holds its own copy of the lexer state.
	class lexer_scoreboard;
		rpl_pkg::token_t expected_tokens[$];
		int              errors;
		rpl_pkg::mode_t  lex_mode;
		logic [7:0]      prev_byte;
		bit              at_start;
		bit              class_open;
		bit              brace_open;
		bit              count_pending;
		longint unsigned count_value;
		logic [3:0]      hex_high;
		int              step_tokens;

		function void clear_pattern();
			lex_mode = rpl_pkg::MODE_NORMAL;
			prev_byte = 8'd0;
			at_start = 1'b1;
			class_open = 1'b0;
			brace_open = 1'b0;
			count_pending = 1'b0;
			count_value = 0;
			hex_high = 4'd0;
		endfunction

		function new();
			errors = 0;
			clear_pattern();
		endfunction

		// at most MAX_RES tokens per byte
		function void put(logic [2:0] kind, logic [15:0] value, logic [1:0] err, logic fin);
			rpl_pkg::token_t t;
			if (step_tokens >= rpl_pkg::MAX_RES)
				return;
			t.token_kind = kind;
			t.token_value = value;
			t.error_code = err;
			t.last_token = fin;
			expected_tokens.insert(expected_tokens.size(), t);
			step_tokens++;
		endfunction

		function int hex_val(logic [7:0] c);
			if (c >= "0" && c <= "9")
				return int'(c - "0");
			if (c >= "a" && c <= "f")
				return int'(c - "a") + 10;
			if (c >= "A" && c <= "F")
				return int'(c - "A") + 10;
			return -1;
		endfunction

		// decoding of a byte outside any escape or group prefix
		function void lex_plain(logic [7:0] c, logic fin);
			longint unsigned cap;
			longint unsigned d;
			logic [15:0]     v;
			cap = (64'd1 << rpl_pkg::COUNT_BITS) - 64'd1;
			v = {8'd0, c};
			case (c)
				rpl_pkg::CH_CARET: put((at_start || prev_byte == "[") ? rpl_pkg::TK_OP :
					rpl_pkg::TK_CHAR, v, rpl_pkg::ERR_NONE, 1'b0);
				rpl_pkg::CH_DOLLAR: put(fin ? rpl_pkg::TK_OP : rpl_pkg::TK_CHAR, v,
					rpl_pkg::ERR_NONE, 1'b0);
				".": put(class_open ? rpl_pkg::TK_CHAR : rpl_pkg::TK_ESC, v,
					rpl_pkg::ERR_NONE, 1'b0);
				rpl_pkg::CH_BSLASH: lex_mode = rpl_pkg::MODE_ESC;
				"[", "]": begin
					class_open = (c == "[");
					put(rpl_pkg::TK_OP, v, rpl_pkg::ERR_NONE, 1'b0);
				end
				"-": put(class_open ? rpl_pkg::TK_OP : rpl_pkg::TK_CHAR, v,
					rpl_pkg::ERR_NONE, 1'b0);
				",": put(brace_open ? rpl_pkg::TK_OP : rpl_pkg::TK_CHAR, v,
					rpl_pkg::ERR_NONE, 1'b0);
				"|", "(", ")", "{", "}", "+", "*", "?": begin
					if (c == "(")
						lex_mode = rpl_pkg::MODE_PAREN;
					brace_open = (c == "{");
					put(class_open ? rpl_pkg::TK_CHAR : rpl_pkg::TK_OP, v,
						rpl_pkg::ERR_NONE, 1'b0);
				end
				default: begin
					if (c >= "0" && c <= "9" && brace_open) begin
						d = 64'(c - 8'h30);
						count_pending = 1'b1;
						if (count_value > (cap - d) / 10)
							count_value = cap;
						else
							count_value = count_value * 10 + d;
					end else
						put(rpl_pkg::TK_CHAR, v, rpl_pkg::ERR_NONE, 1'b0);
				end
			endcase
		endfunction

		// one accepted byte: queue the tokens it should give
		function void note_char(rpl_pkg::char_t ch);
			logic [7:0]  c;
			logic        fin;
			logic [1:0]  err;
			int          h;
			logic [15:0] v;
			c = ch.char_in;
			fin = ch.last_char;
			v = {8'd0, c};
			err = rpl_pkg::ERR_NONE;
			step_tokens = 0;
			if (lex_mode == rpl_pkg::MODE_DRAIN) begin
				if (fin)
					clear_pattern();
				return;
			end
			// pending count flushes ahead of the byte in every mode but drain
			if (count_pending && (c == "," || c == "}")) begin
				put(rpl_pkg::TK_INT, count_value[15:0], rpl_pkg::ERR_NONE, 1'b0);
				count_pending = 1'b0;
				count_value = 0;
			end
			case (lex_mode)
				rpl_pkg::MODE_ESC: begin
					lex_mode = rpl_pkg::MODE_NORMAL;
					case (c)
						"(", ")", "[", "]", "+", "*", "?", ".", rpl_pkg::CH_BSLASH, "|",
						rpl_pkg::CH_CARET, rpl_pkg::CH_DOLLAR, "{", "}", "-":
							put(rpl_pkg::TK_CHAR, v, rpl_pkg::ERR_NONE, 1'b0);
						"n": put(rpl_pkg::TK_CHAR, 16'd10, rpl_pkg::ERR_NONE, 1'b0);
						"t": put(rpl_pkg::TK_CHAR, 16'd9, rpl_pkg::ERR_NONE, 1'b0);
						"r": put(rpl_pkg::TK_CHAR, 16'd13, rpl_pkg::ERR_NONE, 1'b0);
						"v": put(rpl_pkg::TK_CHAR, 16'd11, rpl_pkg::ERR_NONE, 1'b0);
						"f": put(rpl_pkg::TK_CHAR, 16'd12, rpl_pkg::ERR_NONE, 1'b0);
						"e", "w", "W", "d", "D", "s", "S", "a", "A", "l", "L", "u",
						"U": put(rpl_pkg::TK_ESC, v, rpl_pkg::ERR_NONE, 1'b0);
						rpl_pkg::CH_X: lex_mode = rpl_pkg::MODE_HEX1;
						default: err = rpl_pkg::ERR_ESC;
					endcase
				end
				rpl_pkg::MODE_HEX1: begin
					h = hex_val(c);
					if (h < 0)
						err = rpl_pkg::ERR_HEX;
					else begin
						hex_high = h[3:0];
						lex_mode = rpl_pkg::MODE_HEX2;
					end
				end
				rpl_pkg::MODE_HEX2: begin
					h = hex_val(c);
					if (h < 0)
						err = rpl_pkg::ERR_HEX;
					else begin
						put(rpl_pkg::TK_CHAR, {8'd0, hex_high, h[3:0]}, rpl_pkg::ERR_NONE, 1'b0);
						lex_mode = rpl_pkg::MODE_NORMAL;
					end
				end
				rpl_pkg::MODE_QMARK: begin
					if (c == rpl_pkg::CH_BANG || c == rpl_pkg::CH_EQUALS) begin
						put(rpl_pkg::TK_SKIP, v, rpl_pkg::ERR_NONE, 1'b0);
						lex_mode = rpl_pkg::MODE_NORMAL;
					end else
						err = rpl_pkg::ERR_SKIP;
				end
				rpl_pkg::MODE_PAREN: begin
					if (c == "?")
						lex_mode = rpl_pkg::MODE_QMARK;
					else begin
						lex_mode = rpl_pkg::MODE_NORMAL;
						lex_plain(c, fin);
					end
				end
				default: begin
					lex_mode = rpl_pkg::MODE_NORMAL;
					lex_plain(c, fin);
				end
			endcase
			if (err != rpl_pkg::ERR_NONE) begin
				put(rpl_pkg::TK_EOE, v, err, 1'b1);
				if (fin)
					clear_pattern();
				else
					lex_mode = rpl_pkg::MODE_DRAIN;
				return;
			end
			prev_byte = c;
			at_start = 1'b0;
			if (fin) begin
				if (lex_mode == rpl_pkg::MODE_NORMAL)
					put(rpl_pkg::TK_EOE, 16'd0, rpl_pkg::ERR_NONE, 1'b1);
				else
					put(rpl_pkg::TK_EOE, v, (lex_mode == rpl_pkg::MODE_ESC) ?
						rpl_pkg::ERR_ESC : rpl_pkg::ERR_HEX, 1'b1);
				clear_pattern();
			end
		endfunction

		function void check_token(rpl_pkg::token_t got);
			rpl_pkg::token_t want;
			if (expected_tokens.size() == 0) begin
				$error("unexpected token: kind %0d value %0h error %0d last %0b",
					got.token_kind, got.token_value, got.error_code, got.last_token);
				errors++;
				return;
			end
			want = expected_tokens.pop_front();
			if (got.token_kind !== want.token_kind) begin
				$error("token_kind: expected %0d, got %0d", want.token_kind, got.token_kind);
				errors++;
			end
			if (got.token_value !== want.token_value) begin
				$error("token_value: expected %0h, got %0h", want.token_value, got.token_value);
				errors++;
			end
			if (got.error_code !== want.error_code) begin
				$error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
				errors++;
			end
			if (got.last_token !== want.last_token) begin
				$error("last_token: expected %0b, got %0b", want.last_token, got.last_token);
				errors++;
			end
		endfunction
	endclass

	localparam int RANDOM_BYTES = 350;
	localparam int HOLD_CYCLES  = 400;
	localparam int LIMIT_NS     = 4_000_000;

	logic            clk;
	logic            arst_n;
	logic            char_valid;
	logic            char_stall;
	rpl_pkg::char_t  char_data;
	logic            token_valid;
	logic            token_stall;
	rpl_pkg::token_t token_data;

	lexer_scoreboard sb;
	logic [7:0]      pattern_bytes[$];
	int              bytes_sent;
	bit              gaps_on;
	bit              hold_req;
	int              hold_left;

	regex_pattern_lexer_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token_data (token_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the lexer hangs or a transfer is lost.
	initial begin
		#(LIMIT_NS);
		$display("regex_pattern_lexer_top test failed");
		$finish;
	end

	// Both handshakes are sampled mid-cycle: inputs and outputs are settled there
	// and hold until the next rising edge, where the transfer actually happens.
	always @(negedge clk) begin
		if (arst_n) begin
			if (char_valid && !char_stall)
				sb.note_char(char_data);
			if (token_valid && !token_stall)
				sb.check_token(token_data);
		end
	end

	// Token receiver: random stalls, plus one long hold-off on request so that
	// the lexer backs up and stalls the byte side while bytes keep coming.
	initial begin
		bit hold_seen;
		hold_seen = 1'b0;
		token_stall = 1'b0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_seen) begin
				hold_seen = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				token_stall <= 1'b1;
			end else
				token_stall <= gaps_on && ($urandom_range(0, 99) < 10);
		end
	end

	function automatic logic [7:0] pick(string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	function automatic void add_byte(logic [7:0] b);
		pattern_bytes.insert(pattern_bytes.size(), b);
	endfunction

	function automatic void load_text(string s);
		pattern_bytes.delete();
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endfunction

	// one fragment of a pattern; all but the single random byte are well-formed
	function automatic void add_piece();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: begin
				if ($urandom_range(0, 9) == 0)
					add_byte(8'($urandom_range(128, 255)));
				else
					add_byte(8'($urandom_range(32, 126)));
			end
			1: begin
				add_byte(rpl_pkg::CH_BSLASH);
				add_byte(pick("()[]+*?.\\|^${}-ntrvfewWdDsSaAlLuU"));
			end
			2: begin
				add_byte(rpl_pkg::CH_BSLASH);
				add_byte(rpl_pkg::CH_X);
				add_byte(pick("0123456789abcdefABCDEF"));
				add_byte(pick("0123456789abcdefABCDEF"));
			end
			3: begin
				add_byte("(");
				case ($urandom_range(0, 2))
					1: begin
						add_byte("?");
						add_byte(rpl_pkg::CH_EQUALS);
					end
					2: begin
						add_byte("?");
						add_byte(rpl_pkg::CH_BANG);
					end
					default: ;
				endcase
			end
			4: add_byte(")");
			5: begin
				add_byte("[");
				if ($urandom_range(0, 1))
					add_byte(rpl_pkg::CH_CARET);
				repeat ($urandom_range(1, 3))
					add_byte(pick("abz09.-^$,{}|"));
				add_byte("]");
			end
			6: begin
				add_byte("{");
				if ($urandom_range(0, 9) == 0)
					repeat (6) add_byte("9");
				else
					repeat ($urandom_range(1, 3)) add_byte(pick("0123456789"));
				if ($urandom_range(0, 1)) begin
					add_byte(",");
					repeat ($urandom_range(0, 2)) add_byte(pick("0123456789"));
				end
				add_byte("}");
			end
			7: add_byte(pick("|+*?.-,"));
			8: add_byte(rpl_pkg::CH_CARET);
			default: add_byte(rpl_pkg::CH_DOLLAR);
		endcase
	endfunction

	// Mostly well-formed patterns; a quarter are noise or carry one flaw.
	function automatic void make_pattern();
		int flaw;
		pattern_bytes.delete();
		if ($urandom_range(0, 3) != 0) begin
			repeat ($urandom_range(1, 5)) add_piece();
			if ($urandom_range(0, 1))
				add_byte(rpl_pkg::CH_DOLLAR);
			return;
		end
		flaw = $urandom_range(0, 4);
		if (flaw == 0) begin
			repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
			return;
		end
		repeat ($urandom_range(0, 2)) add_piece();
		case (flaw)
			1: begin
				add_byte(rpl_pkg::CH_BSLASH);
				add_byte(pick("qgzkyQ0#"));
			end
			2: begin
				add_byte(rpl_pkg::CH_BSLASH);
				add_byte(rpl_pkg::CH_X);
				if ($urandom_range(0, 1))
					add_byte(pick("09afAF"));
				add_byte(pick("gGzZ_ -@"));
			end
			3: begin
				add_byte("(");
				add_byte("?");
				add_byte(pick("a:<?(x"));
			end
			default: begin
				// pattern cut short inside an escape or a group prefix
				case ($urandom_range(0, 4))
					0: add_byte(rpl_pkg::CH_BSLASH);
					1: begin
						add_byte(rpl_pkg::CH_BSLASH);
						add_byte(rpl_pkg::CH_X);
					end
					2: begin
						add_byte(rpl_pkg::CH_BSLASH);
						add_byte(rpl_pkg::CH_X);
						add_byte("4");
					end
					3: add_byte("(");
					default: begin
						add_byte("(");
						add_byte("?");
					end
				endcase
			end
		endcase
		// after an error the rest is drained
		if (flaw != 4)
			repeat ($urandom_range(0, 3)) add_piece();
	endfunction

	// Offer one byte and hold it until the transfer completes.
	task automatic push_char(input logic [7:0] b, input logic fin);
		bit done;
		if (gaps_on) begin
			while ($urandom_range(0, 99) < 10) begin
				char_valid <= 1'b0;
				@(posedge clk);
			end
		end
		char_valid <= 1'b1;
		char_data <= '{char_in: b, last_char: fin};
		done = 1'b0;
		while (!done) begin
			@(negedge clk);
			done = !char_stall;
			@(posedge clk);
		end
		bytes_sent++;
	endtask

	task automatic send_pattern();
		foreach (pattern_bytes[i])
			push_char(pattern_bytes[i], i == pattern_bytes.size() - 1);
	endtask

	initial begin
		bit hold_done;
		sb = new();
		arst_n = 1'b0;
		char_valid = 1'b0;
		char_data = '0;
		bytes_sent = 0;
		gaps_on = 1'b1;
		hold_req = 1'b0;
		hold_done = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: caret first and after an open bracket, caret as a char, class
		// operators, dollar on the last byte, saturating count flushed by '}' (three
		// tokens from one byte), unknown escape then drain, unfinished hex escape,
		// and a byte above 127.
		load_text("^$");
		send_pattern();
		load_text("a^[^.-]$");
		send_pattern();
		load_text("{99999}");
		send_pattern();
		load_text("\\q!");
		send_pattern();
		load_text("\\x");
		send_pattern();
		pattern_bytes = '{8'hff};
		send_pattern();

		// Random patterns; a quiet stretch with no gaps on either side, and one
		// long hold-off on the token side part way through.
		bytes_sent = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			gaps_on = !(bytes_sent >= 150 && bytes_sent < 250);
			if (!hold_done && bytes_sent >= 100) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			make_pattern();
			send_pattern();
		end
		char_valid <= 1'b0;
		gaps_on = 1'b1;

		while (sb.expected_tokens.size() != 0)
			@(posedge clk);
		// room for any stray token after the last expected one
		repeat (16) @(posedge clk);
		if (sb.errors == 0)
			$display("regex_pattern_lexer_top test passed");
		else
			$display("regex_pattern_lexer_top test failed");
		$finish;
	end

endmodule
